FILE: sv/ibc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// IMU bias calibrator package
// Shared widths, register map, lane control bundle and saturation helpers.
// ============================================================================
package ibc_pkg;

    // Sample words.
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 168;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_ADDR_W-1:0] CFG_WARMUP    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GRAVITY   = 2'd3;

    localparam logic [11:0] RST_WARMUP    = 12'd1000;
    localparam logic [30:0] RST_THRESHOLD = 31'd64;
    localparam logic [15:0] RST_GAIN      = 16'd131;
    localparam logic [14:0] RST_GRAVITY   = 15'd4096;

    // Output buffer sizing; also bounds the beats in flight.
    localparam int OFIFO_DEPTH = 16;
    localparam int OFIFO_PTR_W = 4;
    localparam int OFIFO_CNT_W = 5;

    // Per-lane strobes. sum_en belongs to the first pipeline stage; load and track
    // both belong to the bias update stage.
    typedef struct packed {
        logic sum_en;
        logic load;
        logic track;
    } t_lane_ctl;

    function automatic logic signed [31:0] sat_s32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat_s16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/ibc_lane.sv
`timescale 1ns / 1ps
// ============================================================================
// IMU bias calibrator axis lane
// One axis: calibration sum, mean by reciprocal multiply, bias register with
// optional tracking step, and bias removal with rounding and saturation.
// ============================================================================
module ibc_lane #(
    parameter int CALIB_SAMPLES = 400
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ibc_pkg::t_lane_ctl     i_ctl,
    input  logic signed [15:0]     i_x,
    input  logic [15:0]            i_gain,
    input  logic [14:0]            i_grav,
    output logic signed [15:0]     o_y
);

    localparam int CLOG  = $clog2(CALIB_SAMPLES);
    localparam int SUM_W = 16 + CLOG;
    localparam int X_W   = SUM_W;
    localparam int K     = X_W + CLOG;
    localparam int M_W   = X_W + 2;
    // ceil(2^K / N) gives an exact floor(x / N) for every x below 2^X_W.
    localparam logic [63:0]    RECIP_FULL = ((64'd1 << K) + 64'(CALIB_SAMPLES) - 64'd1)
                                            / 64'(CALIB_SAMPLES);
    localparam logic [M_W-1:0] RECIP      = RECIP_FULL[M_W-1:0];
    localparam logic [X_W-1:0] HALF       = X_W'(CALIB_SAMPLES / 2);
    localparam logic [X_W-1:0] N_X        = X_W'(CALIB_SAMPLES);

    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] r_sum2;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [15:0]      r_xd [2:8];

    logic                    r_neg3, r_neg4, r_neg5, r_neg6;
    logic [X_W-1:0]          r_mag3, r_m4, r_qa4, r_qa5, r_qa6, r_x2_5;
    logic [15:0]             r_q2_6;
    logic [X_W+M_W-1:0]      w_prod1, w_prod2;
    logic [X_W-1:0]          w_ra, w_x2;
    logic [32:0]             w_mag;
    logic signed [33:0]      w_sgn, w_cand;
    logic signed [31:0]      r_cand7;

    logic signed [31:0]      r_bias, r_bias8, n_bias;
    logic signed [32:0]      w_diff;
    logic signed [49:0]      w_prod, w_prod_r;
    logic signed [33:0]      w_step;
    logic signed [35:0]      w_upd;
    logic signed [33:0]      w_d, w_dr;

    // Calibration sum; the copy sent down the pipe includes this sample.
    assign n_sum = r_sum + SUM_W'(i_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.sum_en) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum2  <= i_ctl.sum_en ? n_sum : r_sum;
        r_xd[2] <= i_x;
        for (int k = 3; k <= 8; k++) begin
            r_xd[k] <= r_xd[k-1];
        end
    end

    // Mean: |sum| * 2^16 / N split as qa * 2^16 + (ra * 2^16 + N/2) / N.
    assign w_prod1 = r_mag3 * RECIP;
    assign w_ra    = r_m4 - r_qa4 * N_X;
    assign w_x2    = (w_ra << 16) + HALF;
    assign w_prod2 = r_x2_5 * RECIP;
    assign w_mag   = 33'({r_qa6, r_q2_6});
    assign w_sgn   = r_neg6 ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    assign w_cand  = w_sgn - $signed({3'b000, i_grav, 16'h0000});

    always_ff @(posedge i_clk) begin
        r_neg3  <= r_sum2[SUM_W-1];
        r_mag3  <= r_sum2[SUM_W-1] ? X_W'(-r_sum2) : X_W'(r_sum2);
        r_neg4  <= r_neg3;
        r_m4    <= r_mag3;
        r_qa4   <= X_W'(w_prod1 >> K);
        r_neg5  <= r_neg4;
        r_qa5   <= r_qa4;
        r_x2_5  <= w_x2;
        r_neg6  <= r_neg5;
        r_qa6   <= r_qa5;
        r_q2_6  <= 16'(w_prod2 >> K);
        r_cand7 <= ibc_pkg::sat_s32(36'(w_cand));
    end

    // Tracking step: bias += round(gain * (x * 2^16 - bias) / 2^16).
    // Adding 32767 before the shift rounds negative halfway values away from zero.
    assign w_diff   = 33'($signed({r_xd[7], 16'h0000})) - 33'(r_bias);
    assign w_prod   = w_diff * $signed({1'b0, i_gain});
    assign w_prod_r = w_prod + (w_prod[49] ? 50'sd32767 : 50'sd32768);
    assign w_step   = 34'(w_prod_r >>> 16);
    assign w_upd    = 36'(r_bias) + 36'(w_step);

    always_comb begin
        if (i_ctl.load) begin
            n_bias = r_cand7;
        end else if (i_ctl.track) begin
            n_bias = ibc_pkg::sat_s32(w_upd);
        end else begin
            n_bias = r_bias;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0;
        end else begin
            r_bias <= n_bias;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bias8 <= n_bias;
    end

    // Bias removal with the bias that this sample left behind.
    assign w_d  = 34'($signed({r_xd[8], 16'h0000})) - 34'(r_bias8);
    assign w_dr = w_d + (w_d[33] ? 34'sd32767 : 34'sd32768);
    assign o_y  = ibc_pkg::sat_s16(18'(w_dr >>> 16));

endmodule

FILE: sv/ibc_motion.sv
`timescale 1ns / 1ps
// ============================================================================
// IMU bias calibrator motion detector
// Merges the three gyro axes: squared change from the previous sample,
// summed and compared against the tracking threshold.
// ============================================================================
module ibc_motion (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic [30:0]        i_thr,
    output logic               o_track_ok
);

    logic signed [15:0] w_g    [3];
    logic signed [15:0] r_prev [3];
    logic signed [16:0] w_d    [3];
    logic signed [33:0] w_sq   [3];
    logic [31:0]        r_sq   [3];
    logic [33:0]        w_dsq;

    assign w_g[0] = i_gyro_x;
    assign w_g[1] = i_gyro_y;
    assign w_g[2] = i_gyro_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_d[a]  = 17'(w_g[a]) - 17'(r_prev[a]);
            w_sq[a] = w_d[a] * w_d[a];
        end
    end

    // The previous sample follows every beat, whatever the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_prev[a] <= '0;
            end
        end else if (i_valid) begin
            for (int a = 0; a < 3; a++) begin
                r_prev[a] <= w_g[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_sq[a] <= w_sq[a][31:0];
        end
    end

    // The verdict belongs to the beat one stage after the squares were taken.
    assign w_dsq      = 34'(r_sq[0]) + 34'(r_sq[1]) + 34'(r_sq[2]);
    assign o_track_ok = w_dsq < {3'b000, i_thr};

endmodule

FILE: sv/ibc_ofifo.sv
`timescale 1ns / 1ps
// ============================================================================
// IMU bias calibrator output buffer
// Small FIFO that holds finished beats until the downstream side takes them.
// ============================================================================
module ibc_ofifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic [ibc_pkg::OUT_TDATA_W-1:0] i_data,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [ibc_pkg::OUT_TDATA_W-1:0] o_data
);

    logic [ibc_pkg::OUT_TDATA_W-1:0] r_mem [ibc_pkg::OFIFO_DEPTH];
    logic [ibc_pkg::OFIFO_PTR_W-1:0] r_wptr, r_rptr;
    logic [ibc_pkg::OFIFO_CNT_W-1:0] r_count;
    logic                            w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid & i_ready;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // The upstream credit count keeps pushes from ever overrunning the buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + ibc_pkg::OFIFO_CNT_W'(i_push)
                               - ibc_pkg::OFIFO_CNT_W'(w_pop);
        end
    end

endmodule

FILE: sv/imu_bias_calibrator.sv
`timescale 1ns / 1ps
// ============================================================================
// IMU bias calibrator
// Static accelerometer and gyro bias calibration with gyro bias tracking.
// ============================================================================
// Every input beat yields exactly one output beat, in order. The block takes
// one beat per clock and returns it once the output side is ready; the beat
// passes the eight-stage datapath and then the output buffer, and the buffer
// admits up to sixteen beats in flight before the input side waits.
// After reset the block skips warmup_samples beats with zero bias, then sums
// CALIB_SAMPLES beats per axis; the beat that completes the sum already leaves
// with the new biases (mean of the sum, gravity removed from the Z
// accelerometer bias). From then on each gyro bias follows the rate by
// track_gain whenever the squared rate change since the previous beat is below
// track_threshold_sq. Only reset ends the tracking stage. Temperature and
// magnetometer words pass through untouched. Configuration writes belong in
// idle periods, when no beat is in flight.
// ============================================================================
module imu_bias_calibrator #(
    parameter int CALIB_SAMPLES = 400
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Configuration: 0 warmup_samples, 1 track_threshold_sq, 2 track_gain,
    // 3 gravity_lsb.
    input  logic                            i_cfg_wr_en,
    input  logic [ibc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ibc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,

    // Fields from bit 0 up: temp_in, acc_x_in, acc_y_in, acc_z_in, gyro_x_in,
    // gyro_y_in, gyro_z_in, mag_x_in, mag_y_in, mag_z_in (16 bits each).
    input  logic [ibc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,

    // Fields from bit 0 up: temp_out, acc_x_out, acc_y_out, acc_z_out,
    // gyro_x_out, gyro_y_out, gyro_z_out, mag_x_out, mag_y_out, mag_z_out
    // (16 bits each), stage (2 bits), then zero fill to 168 bits.
    output logic [ibc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready
);

    localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CALIB_SAMPLES - 1);

    // Stage codes reported with every beat.
    localparam logic [1:0] STAGE_WARMUP = 2'd0;
    localparam logic [1:0] STAGE_CALIB  = 2'd1;
    localparam logic [1:0] STAGE_DONE   = 2'd2;

    typedef enum logic [1:0] {
        ST_LEARN = 2'b01,
        ST_TRACK = 2'b10
    } t_state;

    // What a beat does to the bias state.
    typedef enum logic [1:0] {
        ACT_WARM  = 2'd0,
        ACT_ACCUM = 2'd1,
        ACT_FINAL = 2'd2,
        ACT_TRACK = 2'd3
    } t_action;

    typedef struct packed {
        t_action     act;
        logic [1:0]  stage;
        logic        ok;
        logic [63:0] pass;   // mag_z, mag_y, mag_x, temp from the top down
    } t_tag;

    // Configuration registers.
    logic [11:0] r_warmup;
    logic [30:0] r_thr;
    logic [15:0] r_gain;
    logic [14:0] r_grav;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup <= ibc_pkg::RST_WARMUP;
            r_thr    <= ibc_pkg::RST_THRESHOLD;
            r_gain   <= ibc_pkg::RST_GAIN;
            r_grav   <= ibc_pkg::RST_GRAVITY;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                ibc_pkg::CFG_WARMUP:    r_warmup <= i_cfg_wdata[11:0];
                ibc_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_wdata[30:0];
                ibc_pkg::CFG_GAIN:      r_gain   <= i_cfg_wdata[15:0];
                ibc_pkg::CFG_GRAVITY:   r_grav   <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // Input handshake. The credit count covers beats in the datapath and in
    // the output buffer, so the buffer can never overflow.
    logic                            w_accept;
    logic                            w_pop;
    logic [ibc_pkg::OFIFO_CNT_W-1:0] r_out, n_out;
    logic                            r_rdy;

    assign w_accept      = s_axis_tvalid & r_rdy;
    assign s_axis_tready = r_rdy;
    assign w_pop         = m_axis_tvalid & m_axis_tready;
    assign n_out         = r_out + ibc_pkg::OFIFO_CNT_W'(w_accept)
                                 - ibc_pkg::OFIFO_CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
            r_rdy <= 1'b0;
        end else begin
            r_out <= n_out;
            r_rdy <= n_out < ibc_pkg::OFIFO_CNT_W'(ibc_pkg::OFIFO_DEPTH);
        end
    end

    // Stage sequencing. Beats are classified in arrival order as they are
    // accepted; the datapath then applies the action a fixed number of stages
    // later, which keeps the order of state updates intact.
    t_state         r_state, n_state;
    logic [11:0]    r_wcnt, n_wcnt;
    logic [CNT_W-1:0] r_ccnt, n_ccnt;
    t_action        w_act;
    logic [1:0]     w_stage;

    always_comb begin
        n_state = r_state;
        n_wcnt  = r_wcnt;
        n_ccnt  = r_ccnt;
        w_act   = ACT_TRACK;
        w_stage = STAGE_DONE;
        unique case (r_state)
            ST_LEARN: begin
                if (r_wcnt < r_warmup) begin
                    w_act   = ACT_WARM;
                    n_wcnt  = r_wcnt + 12'd1;
                    w_stage = (n_wcnt < r_warmup) ? STAGE_WARMUP : STAGE_CALIB;
                end else if (r_ccnt == CNT_LAST) begin
                    w_act   = ACT_FINAL;
                    n_state = ST_TRACK;
                    w_stage = STAGE_DONE;
                end else begin
                    w_act   = ACT_ACCUM;
                    n_ccnt  = r_ccnt + 1'b1;
                    w_stage = STAGE_CALIB;
                end
            end
            ST_TRACK: begin
                w_act   = ACT_TRACK;
                w_stage = STAGE_DONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LEARN;
            r_wcnt  <= '0;
            r_ccnt  <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
            r_wcnt  <= n_wcnt;
            r_ccnt  <= n_ccnt;
        end
    end

    // Beat pipeline: stage 1 holds the accepted sample, the lanes add it to
    // the sums there, the motion verdict joins at stage 3, biases change at
    // stage 7 and the corrected beat enters the output buffer from stage 8.
    logic                           r_vld [1:8];
    t_tag                           r_tag [1:8];
    logic [ibc_pkg::IN_TDATA_W-1:0] r_in1;
    logic                           w_track_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 8; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[1] <= w_accept;
            for (int k = 2; k <= 8; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in1          <= s_axis_tdata;
        r_tag[1].act   <= w_act;
        r_tag[1].stage <= w_stage;
        r_tag[1].ok    <= 1'b0;
        r_tag[1].pass  <= {s_axis_tdata[159:112], s_axis_tdata[15:0]};
        r_tag[2]       <= r_tag[1];
        r_tag[3]       <= '{act: r_tag[2].act, stage: r_tag[2].stage,
                            ok: w_track_ok, pass: r_tag[2].pass};
        for (int k = 4; k <= 8; k++) begin
            r_tag[k] <= r_tag[k-1];
        end
    end

    ibc_motion u_motion (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_vld[1]),
        .i_gyro_x   ($signed(r_in1[79:64])),
        .i_gyro_y   ($signed(r_in1[95:80])),
        .i_gyro_z   ($signed(r_in1[111:96])),
        .i_thr      (r_thr),
        .o_track_ok (w_track_ok)
    );

    // Lane strobes, each taken from the stage where it acts.
    ibc_pkg::t_lane_ctl w_ctl_acc, w_ctl_gyro;
    logic               w_sum_en, w_load;

    assign w_sum_en = r_vld[1] & ((r_tag[1].act == ACT_ACCUM) || (r_tag[1].act == ACT_FINAL));
    assign w_load   = r_vld[7] & (r_tag[7].act == ACT_FINAL);

    assign w_ctl_acc.sum_en  = w_sum_en;
    assign w_ctl_acc.load    = w_load;
    assign w_ctl_acc.track   = 1'b0;
    assign w_ctl_gyro.sum_en = w_sum_en;
    assign w_ctl_gyro.load   = w_load;
    assign w_ctl_gyro.track  = r_vld[7] & (r_tag[7].act == ACT_TRACK) & r_tag[7].ok;

    // Six axis lanes: accelerometer X, Y, Z then gyro X, Y, Z.
    logic signed [15:0] w_y [6];

    for (genvar a = 0; a < 3; a++) begin : g_acc
        ibc_lane #(
            .CALIB_SAMPLES (CALIB_SAMPLES)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl_acc),
            .i_x     ($signed(r_in1[16*(1+a) +: 16])),
            .i_gain  (r_gain),
            .i_grav  ((a == 2) ? r_grav : 15'd0),
            .o_y     (w_y[a])
        );
    end

    for (genvar g = 0; g < 3; g++) begin : g_gyro
        ibc_lane #(
            .CALIB_SAMPLES (CALIB_SAMPLES)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl_gyro),
            .i_x     ($signed(r_in1[16*(4+g) +: 16])),
            .i_gain  (r_gain),
            .i_grav  (15'd0),
            .o_y     (w_y[3+g])
        );
    end

    // Output beat assembly.
    logic [ibc_pkg::OUT_TDATA_W-1:0] w_beat;

    assign w_beat = {6'b000000, r_tag[8].stage, r_tag[8].pass[63:16],
                     w_y[5], w_y[4], w_y[3], w_y[2], w_y[1], w_y[0],
                     r_tag[8].pass[15:0]};

    ibc_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_vld[8]),
        .i_data  (w_beat),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata)
    );

endmodule
